[design/m4vt_pkg.sv]
// ----------------------------------------------------------------------------
// m4vt_pkg
// shared types and constants of the 4x4 matrix vertex transform
// ----------------------------------------------------------------------------
package m4vt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int TERM_W    = PROD_W - FRAC_BITS;
    localparam int SUM_W     = TERM_W + 2;
    localparam int N_DIM     = 4;
    localparam int N_ROWS    = 3;
    localparam int IDX_W     = 2;

    typedef logic [1:0]               t_action;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic signed [SUM_W-1:0]  t_sum;

    localparam t_action ACT_WRITE = 2'd0;
    localparam t_action ACT_POINT = 2'd1;
    localparam t_action ACT_DIR   = 2'd2;
    localparam t_action ACT_VEC4  = 2'd3;

    localparam t_data FX_ONE = t_data'(64'(1) << FRAC_BITS);
    localparam t_data FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_data FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic ld_term;
        logic ld_out;
    } t_stage_ctl;

endpackage

[design/m4vt_if.sv]
// ----------------------------------------------------------------------------
// m4vt_in_if / m4vt_out_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface m4vt_in_if;
    import m4vt_pkg::*;

    logic    valid;
    logic    ready;
    t_action action;
    t_idx    row;
    t_idx    col;
    t_data   element_value;
    t_data   in_x;
    t_data   in_y;
    t_data   in_z;
    t_data   in_w;

    modport source (
        output valid, action, row, col, element_value, in_x, in_y, in_z, in_w,
        input  ready
    );
    modport sink (
        input  valid, action, row, col, element_value, in_x, in_y, in_z, in_w,
        output ready
    );
endinterface

interface m4vt_out_if;
    import m4vt_pkg::*;

    logic  valid;
    logic  ready;
    t_data out_x;
    t_data out_y;
    t_data out_z;
    t_data out_w;
    logic  overflow;

    modport source (
        output valid, out_x, out_y, out_z, out_w, overflow,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, out_w, overflow,
        output ready
    );
endinterface

[design/m4vt_row.sv]
// ----------------------------------------------------------------------------
// m4vt_row
// one matrix row: products into a term register (the fourth term is the product,
// the element or zero, by action), then sum and saturate into a result register
// ----------------------------------------------------------------------------
module m4vt_row (
    input  logic                 i_clk,
    input  m4vt_pkg::t_stage_ctl i_ctl,
    input  m4vt_pkg::t_action    i_action,
    input  m4vt_pkg::t_data      i_elem [4],
    input  m4vt_pkg::t_data      i_vec  [4],
    output m4vt_pkg::t_data      o_value,
    output logic                 o_ovf
);
    import m4vt_pkg::*;

    t_prod w_prod [N_DIM];
    t_term n_term [N_DIM];
    t_term r_term [N_DIM];
    t_sum  w_sum;
    logic  w_ovf;
    t_data n_value;
    t_data r_value;
    logic  r_ovf;

    always_comb begin
        for (int k = 0; k < N_DIM; k++) begin
            w_prod[k] = t_prod'(i_elem[k]) * t_prod'(i_vec[k]);
            n_term[k] = w_prod[k][PROD_W-1:FRAC_BITS];
        end
        case (i_action)
            ACT_POINT: n_term[N_DIM-1] = t_term'(i_elem[N_DIM-1]);
            ACT_VEC4:  n_term[N_DIM-1] = w_prod[N_DIM-1][PROD_W-1:FRAC_BITS];
            default:   n_term[N_DIM-1] = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_term) begin
            r_term <= n_term;
        end
    end

    always_comb begin
        w_sum = t_sum'(r_term[0]) + t_sum'(r_term[1]) + t_sum'(r_term[2])
              + t_sum'(r_term[3]);
        w_ovf = !((&w_sum[SUM_W-1:DATA_W-1]) || !(|w_sum[SUM_W-1:DATA_W-1]));
        if (!w_ovf) begin
            n_value = w_sum[DATA_W-1:0];
        end else if (w_sum[SUM_W-1]) begin
            n_value = FX_MIN;
        end else begin
            n_value = FX_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_out) begin
            r_value <= n_value;
            r_ovf   <= w_ovf;
        end
    end

    assign o_value = r_value;
    assign o_ovf   = r_ovf;

endmodule

[design/matrix4_vertex_transform.sv]
// ----------------------------------------------------------------------------
// matrix4_vertex_transform
// affine 4x4 matrix times vector in signed Q16.16 with saturation
// ----------------------------------------------------------------------------
// One item is taken per clock unless every stage is full and o_out.ready is
// low. A transform passes through an input register, a product register fed by
// twelve 32x32 multipliers (one per element of the top three rows), and a
// result register after the row sums and saturation. Element writes pass
// through the input register and update the matrix as they leave it, so
// every later transform sees them; they give no result. The stages hold
// only while occupied and blocked, so new items are taken while a result
// waits. The matrix resets to identity.
module matrix4_vertex_transform (
    input  logic              i_clk,
    input  logic              i_rst_n,
    m4vt_in_if.sink           i_in,
    m4vt_out_if.source        o_out
);
    import m4vt_pkg::*;

    t_data      r_matrix [N_DIM*N_DIM];
    logic       r_v1;
    logic       r_v2;
    logic       r_v3;
    t_action    r_act1;
    t_idx       r_row1;
    t_idx       r_col1;
    t_data      r_elem1;
    t_data      r_vec1 [N_DIM];
    t_data      r_w2;
    t_data      r_w3;
    logic       w_ld1;
    logic       w_ld2;
    logic       w_ld3;
    t_stage_ctl w_ctl;
    t_data      w_row_elem [N_ROWS][N_DIM];
    t_data      w_value [N_ROWS];
    logic       w_ovf [N_ROWS];

    assign w_ld3 = !r_v3 || o_out.ready;
    assign w_ld2 = !r_v2 || w_ld3;
    assign w_ld1 = !r_v1 || w_ld2;
    assign w_ctl = '{ld_term: w_ld2, ld_out: w_ld3};

    assign i_in.ready = w_ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            for (int i = 0; i < N_DIM*N_DIM; i++) begin
                r_matrix[i] <= (i % (N_DIM + 1) == 0) ? FX_ONE : '0;
            end
        end else begin
            if (w_ld1) begin
                r_v1 <= i_in.valid;
            end
            if (w_ld2) begin
                r_v2 <= r_v1 && (r_act1 != ACT_WRITE);
            end
            if (w_ld3) begin
                r_v3 <= r_v2;
            end
            if (r_v1 && w_ld2 && r_act1 == ACT_WRITE) begin
                r_matrix[{r_row1, r_col1}] <= r_elem1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_act1    <= i_in.action;
            r_row1    <= i_in.row;
            r_col1    <= i_in.col;
            r_elem1   <= i_in.element_value;
            r_vec1[0] <= i_in.in_x;
            r_vec1[1] <= i_in.in_y;
            r_vec1[2] <= i_in.in_z;
            r_vec1[3] <= i_in.in_w;
        end
        if (w_ld2) begin
            r_w2 <= (r_act1 == ACT_VEC4) ? r_vec1[3] : '0;
        end
        if (w_ld3) begin
            r_w3 <= r_w2;
        end
    end

    always_comb begin
        for (int i = 0; i < N_ROWS; i++) begin
            for (int k = 0; k < N_DIM; k++) begin
                w_row_elem[i][k] = r_matrix[i*N_DIM + k];
            end
        end
    end

    for (genvar g = 0; g < N_ROWS; g++) begin : g_row
        m4vt_row u_row (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_action (r_act1),
            .i_elem   (w_row_elem[g]),
            .i_vec    (r_vec1),
            .o_value  (w_value[g]),
            .o_ovf    (w_ovf[g])
        );
    end

    assign o_out.valid    = r_v3;
    assign o_out.out_x    = w_value[0];
    assign o_out.out_y    = w_value[1];
    assign o_out.out_z    = w_value[2];
    assign o_out.out_w    = r_w3;
    assign o_out.overflow = w_ovf[0] || w_ovf[1] || w_ovf[2];

`ifndef SYNTHESIS
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && w_ld2 && r_act1 == ACT_WRITE |=> !r_v2)
        else $error("write transaction entered the product stage");

    a_reset_identity: assert property (@(posedge i_clk)
        !i_rst_n |=> r_matrix[0] == FX_ONE && r_matrix[5] == FX_ONE
                  && r_matrix[1] == '0 && r_matrix[3] == '0)
        else $error("matrix not identity after reset");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_v1 && r_v2 && r_v3)
        else $error("input stalled with an empty stage");

    a_term_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && w_ld3 |=> r_v3)
        else $error("transform lost between product and result stages");
`endif

endmodule
